FILE: hdl/azm_pkg.sv
// Package for the alarm zone monitor.
// Types, register indexes, zone weights and reset values shared by all azm modules.
// No dependencies.
`default_nettype none

package azm_pkg;

  localparam int unsigned NUM_ZONES  = 6;
  localparam int unsigned NUM_DIG    = 3;
  localparam int unsigned NUM_FIBER  = 3;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned SUM_W      = 6;
  localparam int unsigned PATTERN_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_DISABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIBER_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_LIMIT        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LIMIT       = 2'd3;

  localparam logic [NUM_ZONES-1:0] RST_ZONE_DISABLE    = 6'd1;
  localparam logic [SAMPLE_W-1:0]  RST_FIBER_THRESHOLD = 10'd30;
  localparam logic [CNT_W-1:0]     RST_ON_LIMIT        = 10'd150;
  localparam logic [CNT_W-1:0]     RST_OFF_LIMIT       = 10'd750;

  // restore pattern codes
  localparam logic [PATTERN_W-1:0] PAT_NONE    = 2'd0;
  localparam logic [PATTERN_W-1:0] PAT_PARTIAL = 2'd1;
  localparam logic [PATTERN_W-1:0] PAT_FULL    = 2'd2;

  // lamp state: bit 0 red, bit 1 green
  localparam logic [1:0] LAMP_OFF   = 2'b00;
  localparam logic [1:0] LAMP_RED   = 2'b01;
  localparam logic [1:0] LAMP_GREEN = 2'b10;

  typedef struct packed {
    logic set_normal;
    logic set_alarm;
  } fiber_evt_t;

  typedef struct packed {
    logic                 buzzer;
    logic                 red_led;
    logic                 green_led;
    logic [PATTERN_W-1:0] restore_pattern;
  } alarm_out_t;

  function automatic logic [SUM_W-1:0] zone_weight(input int unsigned z);
    logic [SUM_W-1:0] w;
    unique case (z)
      0:       w = 6'd3;
      1:       w = 6'd5;
      2:       w = 6'd7;
      3:       w = 6'd11;
      4:       w = 6'd13;
      default: w = 6'd17;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/azm_fiber.sv
// One fiber zone debouncer: above/below threshold run counters and confirm bit.
// Depends on azm_pkg.
`default_nettype none

module azm_fiber (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [azm_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [azm_pkg::SAMPLE_W-1:0]  threshold,
  input  wire logic [azm_pkg::CNT_W-1:0]     on_limit,
  input  wire logic [azm_pkg::CNT_W-1:0]     off_limit,
  output azm_pkg::fiber_evt_t                evt
);
  import azm_pkg::*;

  logic [CNT_W-1:0] on_cnt_r, on_cnt_nxt, on_inc;
  logic [CNT_W-1:0] off_cnt_r, off_cnt_nxt, off_inc;
  logic             confirm_r, confirm_nxt;
  logic             on_hit, off_hit;

  always_comb begin
    on_inc  = on_cnt_r + ((sample > threshold && on_cnt_r != CNT_MAX) ? 10'd1 : 10'd0);
    off_inc = off_cnt_r + ((sample < threshold && off_cnt_r != CNT_MAX) ? 10'd1 : 10'd0);
    on_hit  = on_inc > on_limit;
    // an on-run clears both counters, so the off check cannot pass that tick
    off_hit = !on_hit && (off_inc > off_limit);

    on_cnt_nxt  = on_inc;
    off_cnt_nxt = off_inc;
    confirm_nxt = confirm_r;
    evt         = '0;
    if (on_hit) begin
      on_cnt_nxt     = '0;
      off_cnt_nxt    = '0;
      confirm_nxt    = 1'b1;
      evt.set_normal = confirm_r;
    end else if (off_hit) begin
      on_cnt_nxt    = '0;
      off_cnt_nxt   = '0;
      confirm_nxt   = 1'b0;
      evt.set_alarm = !confirm_r;
    end
    if (!step) begin
      evt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_cnt_r  <= '0;
      off_cnt_r <= '0;
      confirm_r <= 1'b0;
    end else if (step) begin
      on_cnt_r  <= on_cnt_nxt;
      off_cnt_r <= off_cnt_nxt;
      confirm_r <= confirm_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/azm_alarm.sv
// Alarm decision: previous sum, inhibit flag, lamp levels, buzzer and restore code.
// Depends on azm_pkg.
`default_nettype none

module azm_alarm (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [azm_pkg::SUM_W-1:0]  sum,
  input  wire logic                       inhibit_press,
  input  wire logic                       resync,
  output azm_pkg::alarm_out_t             res
);
  import azm_pkg::*;

  logic             prev_valid_r;
  logic [SUM_W-1:0] prev_sum_r;
  logic             inhibit_r, inhibit_nxt;
  logic [1:0]       lamp_r, lamp_nxt;
  logic             pv, inh;

  always_comb begin
    pv  = prev_valid_r && !resync;
    inh = inhibit_r || inhibit_press;

    lamp_nxt            = lamp_r;
    res.buzzer          = 1'b0;
    res.restore_pattern = PAT_NONE;
    priority if (pv && prev_sum_r > sum) begin
      res.restore_pattern = (sum == '0) ? PAT_FULL : PAT_PARTIAL;
    end else if (sum != '0 && !inh) begin
      res.buzzer = 1'b1;
      lamp_nxt   = LAMP_RED;
    end else if (inh) begin
      lamp_nxt = lamp_r;
    end else begin
      lamp_nxt = LAMP_GREEN;
    end
    res.red_led   = lamp_nxt[0];
    res.green_led = lamp_nxt[1];

    inhibit_nxt = inh;
    if ((!pv || prev_sum_r != sum) && (!pv || prev_sum_r < sum || sum == '0)) begin
      inhibit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      prev_sum_r   <= '0;
      inhibit_r    <= 1'b0;
      lamp_r       <= LAMP_OFF;
    end else if (step) begin
      // sum is stored every tick: when unchanged it equals the held value
      prev_valid_r <= 1'b1;
      prev_sum_r   <= sum;
      inhibit_r    <= inhibit_nxt;
      lamp_r       <= lamp_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/alarm_zone_monitor_unit.sv
// Top level of the alarm zone monitor: input register, zone levels, alarm sum, result register.
// Depends on azm_pkg, azm_fiber and azm_alarm.
// A word accepted into the input register passes to the result register, which drives out_*.
// One word per cycle unless out_ready stalls; the only loop is the zone/alarm state update.
// Backpressure stalls the input register; while a result waits it takes a word only when empty.
// Reset (rst_n low, synchronous): all zones alarmed, counters and flags clear, lamps off,
// registers at defaults. Config writes are accepted every cycle.
`default_nettype none

module alarm_zone_monitor_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [azm_pkg::NUM_DIG-1:0]    in_digital_zones,
  input  wire logic [azm_pkg::SAMPLE_W-1:0]   in_fiber_a,
  input  wire logic [azm_pkg::SAMPLE_W-1:0]   in_fiber_b,
  input  wire logic [azm_pkg::SAMPLE_W-1:0]   in_fiber_c,
  input  wire logic                           in_inhibit_press,
  input  wire logic                           in_resync,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic                           out_buzzer,
  output      logic                           out_red_led,
  output      logic                           out_green_led,
  output      logic [azm_pkg::PATTERN_W-1:0]  out_restore_pattern,
  output      logic [azm_pkg::SUM_W-1:0]      out_alarm_sum,
  output      logic [azm_pkg::NUM_ZONES-1:0]  out_zone_normal,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [azm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [azm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import azm_pkg::*;

  // configuration
  logic [NUM_ZONES-1:0] zone_disable_r;
  logic [SAMPLE_W-1:0]  fiber_threshold_r;
  logic [CNT_W-1:0]     on_limit_r, off_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_disable_r    <= RST_ZONE_DISABLE;
      fiber_threshold_r <= RST_FIBER_THRESHOLD;
      on_limit_r        <= RST_ON_LIMIT;
      off_limit_r       <= RST_OFF_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ZONE_DISABLE:    zone_disable_r    <= cfg_data[NUM_ZONES-1:0];
        REG_FIBER_THRESHOLD: fiber_threshold_r <= cfg_data[SAMPLE_W-1:0];
        REG_ON_LIMIT:        on_limit_r        <= cfg_data[CNT_W-1:0];
        REG_OFF_LIMIT:       off_limit_r       <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                s1_valid_r;
  logic [NUM_DIG-1:0]  s1_dig_r;
  logic [SAMPLE_W-1:0] s1_fib_r [NUM_FIBER];
  logic                s1_press_r, s1_resync_r;
  logic                advance;

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dig_r    <= in_digital_zones;
      s1_fib_r[0] <= in_fiber_a;
      s1_fib_r[1] <= in_fiber_b;
      s1_fib_r[2] <= in_fiber_c;
      s1_press_r  <= in_inhibit_press;
      s1_resync_r <= in_resync;
    end
  end

  // fiber zones
  fiber_evt_t fib_evt [NUM_FIBER];

  for (genvar k = 0; k < NUM_FIBER; k++) begin : g_fiber
    azm_fiber u_fiber (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (advance && !zone_disable_r[NUM_DIG+k]),
      .sample    (s1_fib_r[k]),
      .threshold (fiber_threshold_r),
      .on_limit  (on_limit_r),
      .off_limit (off_limit_r),
      .evt       (fib_evt[k])
    );
  end

  // zone levels and alarm sum
  logic [NUM_ZONES-1:0] zone_level_r, zone_level_nxt;
  logic [SUM_W-1:0]     sum;

  always_comb begin
    zone_level_nxt = zone_level_r;
    if (!zone_disable_r[0]) zone_level_nxt[0] = s1_dig_r[0];
    if (!zone_disable_r[1]) zone_level_nxt[1] = !s1_dig_r[1];  // zone 1 is normal low
    if (!zone_disable_r[2]) zone_level_nxt[2] = s1_dig_r[2];
    for (int k = 0; k < NUM_FIBER; k++) begin
      if (fib_evt[k].set_normal) zone_level_nxt[NUM_DIG+k] = 1'b1;
      if (fib_evt[k].set_alarm)  zone_level_nxt[NUM_DIG+k] = 1'b0;
    end
    sum = '0;
    for (int z = 0; z < NUM_ZONES; z++) begin
      if (!zone_disable_r[z] && !zone_level_nxt[z]) sum = sum + zone_weight(z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_level_r <= '0;
    end else if (advance) begin
      zone_level_r <= zone_level_nxt;
    end
  end

  alarm_out_t alarm_res;

  azm_alarm u_alarm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .sum           (sum),
    .inhibit_press (s1_press_r),
    .resync        (s1_resync_r),
    .res           (alarm_res)
  );

  // result register
  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_buzzer          <= alarm_res.buzzer;
      out_red_led         <= alarm_res.red_led;
      out_green_led       <= alarm_res.green_led;
      out_restore_pattern <= alarm_res.restore_pattern;
      out_alarm_sum       <= sum;
      out_zone_normal     <= zone_level_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: bench/azm_alarm_monitor_check.sv
// Watches the in_, out_ and cfg_ channels of the alarm zone monitor, predicts each result word
// and compares it against the block's output; reports a running error count to the bench top.
// Depends on azm_pkg.
`timescale 1ns / 1ps

module azm_alarm_monitor_check (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [azm_pkg::NUM_DIG-1:0]    in_digital_zones,
  input  wire logic [azm_pkg::SAMPLE_W-1:0]   in_fiber_a,
  input  wire logic [azm_pkg::SAMPLE_W-1:0]   in_fiber_b,
  input  wire logic [azm_pkg::SAMPLE_W-1:0]   in_fiber_c,
  input  wire logic                           in_inhibit_press,
  input  wire logic                           in_resync,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           out_buzzer,
  input  wire logic                           out_red_led,
  input  wire logic                           out_green_led,
  input  wire logic [azm_pkg::PATTERN_W-1:0]  out_restore_pattern,
  input  wire logic [azm_pkg::SUM_W-1:0]      out_alarm_sum,
  input  wire logic [azm_pkg::NUM_ZONES-1:0]  out_zone_normal,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [azm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [azm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  errors,
  output int                                  outstanding,
  output int                                  checked
);
  import azm_pkg::*;

  typedef struct packed {
    logic                 buzzer;
    logic                 red_led;
    logic                 green_led;
    logic [PATTERN_W-1:0] restore_pattern;
    logic [SUM_W-1:0]     alarm_sum;
    logic [NUM_ZONES-1:0] zone_normal;
  } alarm_word_t;

  // index z holds the weight of zone z
  localparam logic [5:0][SUM_W-1:0] ZONE_WEIGHT = {6'd17, 6'd13, 6'd11, 6'd7, 6'd5, 6'd3};

  // register copies
  logic [NUM_ZONES-1:0] zone_dis;
  logic [SAMPLE_W-1:0]  thresh;
  logic [CNT_W-1:0]     on_lim, off_lim;

  // zone and alarm state
  logic [NUM_ZONES-1:0]           level;
  logic [NUM_FIBER-1:0]           confirm;
  logic [NUM_FIBER-1:0][CNT_W-1:0] on_cnt, off_cnt;
  logic                           prev_ok, inhibit_f;
  logic [SUM_W-1:0]               prev_sum;
  logic [1:0]                     lamp;

  alarm_word_t pending_alarms[$];
  int n_bad = 0;
  int n_checked = 0;

  initial begin
    errors = 0;
    outstanding = 0;
    checked = 0;
  end

  function automatic alarm_word_t alarm_tick(input logic [NUM_DIG-1:0] dz,
                                             input logic [SAMPLE_W-1:0] fa, fb, fc,
                                             input logic inh, rsy);
    alarm_word_t r;
    logic [NUM_FIBER-1:0][SAMPLE_W-1:0] smp;
    logic [SUM_W-1:0] sum;
    logic [PATTERN_W-1:0] pat;
    logic buz;
    smp = {fc, fb, fa};
    sum = '0;
    pat = PAT_NONE;
    buz = 1'b0;
    if (inh) inhibit_f = 1'b1;
    if (rsy) prev_ok = 1'b0;
    if (!zone_dis[0]) level[0] = dz[0];
    if (!zone_dis[1]) level[1] = !dz[1];   // zone 1 is normal when its pin is low
    if (!zone_dis[2]) level[2] = dz[2];
    for (int k = 0; k < NUM_FIBER; k++) begin
      if (!zone_dis[3+k]) begin
        if (smp[k] > thresh && on_cnt[k] != CNT_MAX) on_cnt[k] = on_cnt[k] + 1'b1;
        if (smp[k] < thresh && off_cnt[k] != CNT_MAX) off_cnt[k] = off_cnt[k] + 1'b1;
        // on check first; it clears both counters so the off check can't fire too
        if (on_cnt[k] > on_lim) begin
          on_cnt[k] = '0;
          off_cnt[k] = '0;
          if (confirm[k]) level[3+k] = 1'b1;
          confirm[k] = 1'b1;
        end
        if (off_cnt[k] > off_lim) begin
          on_cnt[k] = '0;
          off_cnt[k] = '0;
          if (!confirm[k]) level[3+k] = 1'b0;
          confirm[k] = 1'b0;
        end
      end
    end
    for (int z = 0; z < NUM_ZONES; z++)
      if (!zone_dis[z] && !level[z]) sum = sum + ZONE_WEIGHT[z];

    if (prev_ok && prev_sum > sum) begin
      pat = (sum == 0) ? PAT_FULL : PAT_PARTIAL;
    end else if (sum != 0 && !inhibit_f) begin
      buz = 1'b1;
      lamp = LAMP_RED;
    end else if (!inhibit_f) begin
      lamp = LAMP_GREEN;
    end

    if (!prev_ok || prev_sum != sum) begin
      if (!prev_ok || prev_sum < sum || sum == 0) inhibit_f = 1'b0;
      prev_sum = sum;
      prev_ok = 1'b1;
    end

    r.buzzer = buz;
    r.red_led = lamp[0];
    r.green_led = lamp[1];
    r.restore_pattern = pat;
    r.alarm_sum = sum;
    r.zone_normal = level;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    alarm_word_t got, want;
    if (!rst_n) begin
      zone_dis = RST_ZONE_DISABLE;
      thresh = RST_FIBER_THRESHOLD;
      on_lim = RST_ON_LIMIT;
      off_lim = RST_OFF_LIMIT;
      level = '0;
      confirm = '0;
      on_cnt = '0;
      off_cnt = '0;
      prev_ok = 1'b0;
      inhibit_f = 1'b0;
      prev_sum = '0;
      lamp = LAMP_OFF;
      pending_alarms.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ZONE_DISABLE:    zone_dis = cfg_data[NUM_ZONES-1:0];
          REG_FIBER_THRESHOLD: thresh = cfg_data[SAMPLE_W-1:0];
          REG_ON_LIMIT:        on_lim = cfg_data[CNT_W-1:0];
          REG_OFF_LIMIT:       off_lim = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      // compare before pushing: a word leaving now belongs to an earlier tick
      if (out_valid && out_ready) begin
        got.buzzer = out_buzzer;
        got.red_led = out_red_led;
        got.green_led = out_green_led;
        got.restore_pattern = out_restore_pattern;
        got.alarm_sum = out_alarm_sum;
        got.zone_normal = out_zone_normal;
        if (pending_alarms.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result word: sum %0d zones %b", got.alarm_sum, got.zone_normal);
        end else begin
          want = pending_alarms.pop_front();
          n_checked++;
          if (got.buzzer !== want.buzzer || got.red_led !== want.red_led ||
              got.green_led !== want.green_led ||
              got.restore_pattern !== want.restore_pattern ||
              got.alarm_sum !== want.alarm_sum || got.zone_normal !== want.zone_normal) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"result %0d mismatch (exp/got): buzzer %b/%b red %b/%b green %b/%b ",
                        "pattern %0d/%0d sum %0d/%0d zones %b/%b"}, n_checked,
                       want.buzzer, got.buzzer, want.red_led, got.red_led,
                       want.green_led, got.green_led, want.restore_pattern,
                       got.restore_pattern, want.alarm_sum, got.alarm_sum,
                       want.zone_normal, got.zone_normal);
          end
        end
      end
      if (in_valid && in_ready)
        pending_alarms.push_back(alarm_tick(in_digital_zones, in_fiber_a, in_fiber_b,
                                            in_fiber_c, in_inhibit_press, in_resync));
    end
    outstanding <= pending_alarms.size();
    errors <= n_bad;
    checked <= n_checked;
  end

endmodule

FILE: bench/alarm_zone_monitor_unit_test.sv
// Bench top for alarm_zone_monitor_unit: clock, reset, register writes, tick stimulus
// and the verdict. Result checking lives in azm_alarm_monitor_check; depends on azm_pkg.
`timescale 1ns / 1ps

module alarm_zone_monitor_unit_test;
  import azm_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [NUM_DIG-1:0]    in_digital_zones = '0;
  logic [SAMPLE_W-1:0]   in_fiber_a = '0;
  logic [SAMPLE_W-1:0]   in_fiber_b = '0;
  logic [SAMPLE_W-1:0]   in_fiber_c = '0;
  logic in_inhibit_press = 1'b0;
  logic in_resync = 1'b0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic out_buzzer, out_red_led, out_green_led;
  logic [PATTERN_W-1:0]  out_restore_pattern;
  logic [SUM_W-1:0]      out_alarm_sum;
  logic [NUM_ZONES-1:0]  out_zone_normal;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, outstanding, checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int settings_used = 0;
  int quiet = 0;

  alarm_zone_monitor_unit dut (.*);

  azm_alarm_monitor_check alarm_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
          $display("[alarm_zone_monitor_unit] ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [NUM_DIG-1:0] dz, input logic [SAMPLE_W-1:0] fa, fb, fc,
                           input logic inh, rsy);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_digital_zones <= dz;
    in_fiber_a <= fa;
    in_fiber_b <= fb;
    in_fiber_c <= fc;
    in_inhibit_press <= inh;
    in_resync <= rsy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [NUM_ZONES-1:0] dis, input logic [SAMPLE_W-1:0] thr,
                               input logic [CNT_W-1:0] onl, offl);
    write_reg(REG_ZONE_DISABLE, CFG_DATA_W'(dis));
    write_reg(REG_FIBER_THRESHOLD, thr);
    write_reg(REG_ON_LIMIT, onl);
    write_reg(REG_OFF_LIMIT, offl);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // outstanding is registered, so look only after the last accept has been seen
  task automatic wait_idle();
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] fiber_sample(input logic lit,
                                                       input logic [SAMPLE_W-1:0] thr,
                                                       input int noise);
    int r;
    logic [SAMPLE_W-1:0] v;
    r = $urandom_range(99);
    if (r < noise / 2) begin
      v = thr;
    end else if (r < noise) begin
      v = SAMPLE_W'($urandom_range(1023));
    end else if (lit) begin
      v = (thr == '1) ? thr : SAMPLE_W'($urandom_range(1023, thr + 1));
    end else begin
      v = (thr == 0) ? thr : SAMPLE_W'($urandom_range(thr - 1, 0));
    end
    return v;
  endfunction

  // random ticks: lit runs per fiber flip at flip_pm per mille, digital pins toggle now and then
  task automatic run_phase(input logic [NUM_ZONES-1:0] dis, input logic [SAMPLE_W-1:0] thr,
                           input logic [CNT_W-1:0] onl, offl, input int idle, stall, n,
                           input int flip_pm, noise, input logic [NUM_FIBER-1:0] lit_init);
    logic [NUM_DIG-1:0] dz;
    logic [NUM_FIBER-1:0] lit;
    wait_idle();
    load_settings(dis, thr, onl, offl);
    idle_pct = idle;
    stall_pct = stall;
    dz = NUM_DIG'($urandom_range(7));
    lit = lit_init;
    for (int i = 0; i < n; i++) begin
      for (int b = 0; b < NUM_DIG; b++)
        if ($urandom_range(99) < 10) dz[b] = ~dz[b];
      for (int k = 0; k < NUM_FIBER; k++)
        if ($urandom_range(999) < flip_pm) lit[k] = ~lit[k];
      send_word(dz, fiber_sample(lit[0], thr, noise), fiber_sample(lit[1], thr, noise),
                fiber_sample(lit[2], thr, noise), $urandom_range(99) < 8,
                $urandom_range(99) < 5);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: confirm runs, threshold ties, inhibit, resync, partial and full restore
    load_settings(6'h00, 10'd30, 10'd0, 10'd1);
    send_word(3'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
    send_word(3'd7, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0);
    send_word(3'd7, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0);
    send_word(3'd5, 10'd30, 10'd30, 10'd30, 1'b0, 1'b0);
    send_word(3'd5, 10'd30, 10'd30, 10'd30, 1'b1, 1'b0);
    send_word(3'd4, 10'd31, 10'd31, 10'd31, 1'b0, 1'b0);
    send_word(3'd4, 10'd31, 10'd31, 10'd31, 1'b1, 1'b0);
    send_word(3'd6, 10'd31, 10'd31, 10'd31, 1'b0, 1'b0);
    send_word(3'd6, 10'd31, 10'd31, 10'd31, 1'b0, 1'b0);
    send_word(3'd4, 10'd31, 10'd31, 10'd31, 1'b0, 1'b0);
    send_word(3'd4, 10'd31, 10'd31, 10'd31, 1'b0, 1'b1);
    send_word(3'd5, 10'd31, 10'd31, 10'd31, 1'b1, 1'b1);
    send_word(3'd5, 10'd0, 10'd29, 10'd0, 1'b0, 1'b0);
    send_word(3'd5, 10'd0, 10'd29, 10'd0, 1'b0, 1'b0);
    send_word(3'd5, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
    send_word(3'd5, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
    send_word(3'd2, 10'd1023, 10'd0, 10'd512, 1'b0, 1'b0);
    in_valid <= 1'b0;
    wait_idle();
    // odd zones frozen, threshold at top so 1023 ties
    load_settings(6'b101010, 10'd1023, 10'd0, 10'd0);
    send_word(3'd7, 10'd1023, 10'd0, 10'd1023, 1'b0, 1'b0);
    send_word(3'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
    send_word(3'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
    send_word(3'd7, 10'd1022, 10'd1023, 10'd1, 1'b1, 1'b1);
    in_valid <= 1'b0;

    run_phase(6'h00, 10'd30, 10'd3, 10'd5, 0, 0, 150, 40, 12, 3'b000);
    run_phase(6'h3F, 10'd0, 10'd0, 10'd0, 83, 0, 80, 40, 12, 3'b111);
    run_phase(NUM_ZONES'($urandom_range(63)), 10'd1023, 10'd1, 10'd2, 0, 83, 120, 60, 12,
              3'b010);
    run_phase(6'h00, 10'd512, 10'd10, 10'd12, 30, 30, 300, 20, 12, 3'b101);
    run_phase(RST_ZONE_DISABLE, 10'd30, 10'd0, 10'd0, 0, 0, 100, 60, 12, 3'b011);
    run_phase(NUM_ZONES'($urandom_range(63)), SAMPLE_W'($urandom_range(1023)),
              CNT_W'($urandom_range(8)), CNT_W'($urandom_range(8)),
              83, 0, 150, 40, 12, NUM_FIBER'($urandom_range(7)));
    run_phase(6'h00, 10'd200, 10'd0, 10'd1023, 30, 30, 80, 50, 12, 3'b110);

    wait_idle();
    $display("checked %0d result words for %0d ticks under %0d register settings",
             checked, words_sent, settings_used);
    $display("idle mixes: none, sender 83%%, receiver 83%%, both 30%%; incl. frozen zones");
    if (errors == 0 && outstanding == 0) begin
      $display("[alarm_zone_monitor_unit] OK");
    end else begin
      $display("[alarm_zone_monitor_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/azm_pkg.sv
hdl/azm_fiber.sv
hdl/azm_alarm.sv
hdl/alarm_zone_monitor_unit.sv
bench/azm_alarm_monitor_check.sv
bench/alarm_zone_monitor_unit_test.sv
